FILE: rtl/core/gf128ma_pkg.sv
// ----------------------------------------------------------------------------
// gf128ma_pkg: shared types and constants
// Holds the per-stage item struct, the pipeline geometry and the register map
// of the GF(2^128) multiply-accumulate block.
// ----------------------------------------------------------------------------
`default_nettype none

package gf128ma_pkg;

    // Field geometry
    localparam int unsigned FIELD_W      = 128;
    localparam int unsigned HALF_W       = 64;
    localparam int unsigned RED_W        = 8;

    // Pipeline geometry: eight multiplier bits consumed per stage
    localparam int unsigned STEPS        = 8;
    localparam int unsigned NUM_STAGES   = FIELD_W / STEPS;

    // Stream widths
    localparam int unsigned IN_DATA_W    = 6 * HALF_W;
    localparam int unsigned OUT_DATA_W   = 2 * HALF_W;

    // Configuration port
    localparam int unsigned APB_ADDR_W   = 2;
    localparam int unsigned APB_DATA_W   = 32;
    localparam logic [APB_ADDR_W-1:0] REG_REDUCTION = 2'd0;
    localparam logic [RED_W-1:0]      RED_RESET     = 8'hE1;

    // Work item carried down the pipeline
    typedef struct packed {
        logic [FIELD_W-1:0] a;   // multiplicand, shifted and reduced per step
        logic [FIELD_W-1:0] b;   // multiplier, next bit to use at bit 0
        logic [FIELD_W-1:0] s;   // running sum, starts at the accumulator
    } t_item;

endpackage

`default_nettype wire

FILE: rtl/core/gf128_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// gf128_multiply_accumulate: pipelined GF(2^128) multiply-accumulate
// Returns acc ^ (a * b) using bit-serial shift-and-add over b, spread across
// a pipeline of stages of eight steps each.
//
//  Channel  Dir  Handshake                 Contents
//  s_*      in   s_tvalid / s_tready       a_low, a_high, b_low, b_high,
//                                          acc_low, acc_high
//  m_*      out  m_tvalid / m_tready       product_low, product_high
//  APB      in   psel & penable & pwrite   reduction_low_byte at address 0
//
// The result is registered through the NUM_STAGES stages; one transaction
// per cycle is sustained while m_tready is high.
// The last stage register is the output register; a stall on m_tready holds
// every full stage with no empty stage after it, while the others keep filling.
// Reset (synchronous, active low) empties the pipeline and loads 0xE1.
// ----------------------------------------------------------------------------
`default_nettype none

module gf128_multiply_accumulate
    import gf128ma_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // a_low, a_high, b_low, b_high, acc_low, acc_high (64 bits each)
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // Output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // product_low, product_high (64 bits each)
    output logic      [OUT_DATA_W-1:0] m_tdata,
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [RED_W-1:0]        red;
    logic [NUM_STAGES:0]     vld;
    logic [NUM_STAGES:0]     rdy;
    t_item                   item [NUM_STAGES+1];

    // Configuration registers
    gf128ma_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_red   (red)
    );

    // Unpack the input transaction
    assign vld[0]    = s_tvalid;
    assign item[0].a = s_tdata[2*HALF_W-1:0];
    assign item[0].b = s_tdata[4*HALF_W-1:2*HALF_W];
    assign item[0].s = s_tdata[6*HALF_W-1:4*HALF_W];
    assign s_tready  = rdy[0];

    // Stage chain
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        gf128ma_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_red     (red),
            .i_vld     (vld[k]),
            .i_item    (item[k]),
            .o_rdy     (rdy[k]),
            .i_nxt_rdy (rdy[k+1]),
            .o_vld     (vld[k+1]),
            .o_item    (item[k+1])
        );
    end

    // Drive the output from the last stage
    assign rdy[NUM_STAGES] = m_tready;
    assign m_tvalid        = vld[NUM_STAGES];
    assign m_tdata         = item[NUM_STAGES].s;

    // Output ready must reach the input through the whole chain
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tready |-> s_tready)
        else $error("ready chain broken");

    // An accepted transaction lands in the first stage
    a_first_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> vld[1])
        else $error("accepted transaction lost at first stage");

    // Reset loads the default reduction byte
    a_red_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (red == RED_RESET))
        else $error("reduction byte not at reset value");

    // The second-to-last stage, when full and unable to advance, holds its valid
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vld[NUM_STAGES-1] && !rdy[NUM_STAGES-1]) |=> vld[NUM_STAGES-1])
        else $error("stalled stage dropped its item");

endmodule

`default_nettype wire

FILE: rtl/core/gf128ma_regs.sv
// ----------------------------------------------------------------------------
// gf128ma_regs: configuration register file
// APB-style slave holding the reduction byte; always ready, zero wait states.
// ----------------------------------------------------------------------------
`default_nettype none

module gf128ma_regs
    import gf128ma_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [RED_W-1:0]      o_red
);

    logic [RED_W-1:0] r_red;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Capture the reduction byte on a write transaction to its address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red <= RED_RESET;
        end else if (wr_en && (paddr == REG_REDUCTION)) begin
            r_red <= pwdata[RED_W-1:0];
        end
    end

    // Read back; unused addresses read as zero
    always_comb begin
        prdata = '0;
        if (paddr == REG_REDUCTION) begin
            prdata = {{(APB_DATA_W-RED_W){1'b0}}, r_red};
        end
    end

    assign o_red = r_red;

endmodule

`default_nettype wire

FILE: rtl/core/gf128ma_stage.sv
// ----------------------------------------------------------------------------
// gf128ma_stage: one pipeline stage of the shift-and-add multiplier
// Consumes STEPS bits of b: add a into the sum where the bit is set, then
// shift a left by one and fold the overflow bit back with the reduction byte.
// ----------------------------------------------------------------------------
`default_nettype none

module gf128ma_stage
    import gf128ma_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [RED_W-1:0] i_red,
    input  wire logic             i_vld,
    input  wire t_item            i_item,
    output logic                  o_rdy,
    input  wire logic             i_nxt_rdy,
    output logic                  o_vld,
    output t_item                 o_item
);

    logic  r_vld;
    t_item r_item;
    t_item n_item;

    // Accept when empty or when the content moves on this cycle
    assign o_rdy = !r_vld || i_nxt_rdy;

    // Run STEPS shift-and-add steps on the incoming item
    always_comb begin
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] s;
        logic               top;
        a   = i_item.a;
        s   = i_item.s;
        top = 1'b0;
        for (int j = 0; j < STEPS; j++) begin
            if (i_item.b[j]) begin
                s = s ^ a;
            end
            top = a[FIELD_W-1];
            a   = {a[FIELD_W-2:0], 1'b0};
            if (top) begin
                a[RED_W-1:0] = a[RED_W-1:0] ^ i_red;
            end
        end
        n_item.a = a;
        n_item.b = i_item.b >> STEPS;
        n_item.s = s;
    end

    // Advance valid under the ready chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    // Load payload only with a valid item
    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire
